// ===== rtl/cke_pkg.sv =====
// ---------------------------------------------------------------------------
// cke_pkg
// Shared types, constants and report helpers of the keystroke encoder.
// ---------------------------------------------------------------------------
package cke_pkg;

    // Field widths of the stream words
    localparam int CODE_W     = 16;
    localparam int MOD_W      = 8;
    localparam int KEY_W      = 7;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 5;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // HID modifier and key constants
    localparam logic [MOD_W-1:0] MOD_NONE   = 8'h00;
    localparam logic [MOD_W-1:0] MOD_SHIFT  = 8'h20;
    localparam logic [MOD_W-1:0] MOD_ALT    = 8'h40;
    localparam logic [KEY_W-1:0] KEY_NONE   = 7'd0;
    localparam logic [KEY_W-1:0] DIGIT_BASE = 7'd88;
    localparam logic [KEY_W-1:0] ZERO_KEY   = 7'd98;

    // Divide by ten: q = (v * 52429) >> 19, exact for every 16-bit v
    localparam logic [CODE_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int                DIV10_SHIFT = 19;

    // Report sequencing
    localparam int                STEP_W          = 4;
    localparam logic [STEP_W-1:0] FIRST_STEP      = 4'd0;
    localparam logic [STEP_W-1:0] PLAIN_LAST_STEP = 4'd1;
    localparam logic [STEP_W-1:0] ALT_LAST_STEP   = 4'd11;

    // Front-end sequencer states
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    // One classified character, as queued for the back end
    typedef struct packed {
        logic                                is_alt;
        logic [MOD_W-1:0]                    plain_mod;
        logic [KEY_W-1:0]                    plain_key;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;    // index 0 is most significant
    } desc_t;

    // One keyboard report
    typedef struct packed {
        logic [MOD_W-1:0] modifier_bits;
        logic [KEY_W-1:0] key_code;
        logic             last_report;
    } report_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Keypad key for one decimal digit
    function automatic logic [KEY_W-1:0] digit_key(logic [DIGIT_W-1:0] d);
        logic [KEY_W-1:0] k;
        if (d == '0) begin
            k = ZERO_KEY;
        end else begin
            k = KEY_W'(d) + DIGIT_BASE;
        end
        return k;
    endfunction

    // Report number 'step' of a classified character
    function automatic report_t make_report(desc_t d, logic [STEP_W-1:0] step);
        report_t          r;
        logic [STEP_W-1:0] idx_wide;
        logic [2:0]        idx;
        r        = '0;
        idx_wide = (step - 4'd1) >> 1;
        idx      = idx_wide[2:0];
        if (!d.is_alt) begin
            if (step == FIRST_STEP) begin
                r.modifier_bits = d.plain_mod;
                r.key_code      = d.plain_key;
            end else begin
                r.last_report = 1'b1;
            end
        end else if (step == ALT_LAST_STEP) begin
            r.last_report = 1'b1;
        end else begin
            r.modifier_bits = MOD_ALT;
            // odd steps press a digit, even steps release
            if (step[0]) begin
                r.key_code = digit_key(d.digits[idx]);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/char_to_keystroke_encoder_top.sv =====
// ---------------------------------------------------------------------------
// char_to_keystroke_encoder_top
// Character code to keyboard report sequence encoder.
// ---------------------------------------------------------------------------
// Input stream carries one 16-bit character code per word. A code with a
// zero high byte types as a press and a release (two reports); a code with
// a nonzero high byte types as an alt-code of five keypad digits (twelve
// reports); a zero code is taken and produces nothing.
// Output stream carries one report per word, tlast on the final report.
// A plain code reaches the output through the queue and the output register;
// an alt code first passes the front's divide state, which splits it into
// digits with one divide-by-ten multiply per cycle.
// Throughput: the output runs one report per cycle while the receiver takes
// them; the front takes a plain code every cycle while the queue has room,
// and takes no new code while an alt code is split and pushed.
// A queue of QUEUE_DEPTH characters separates front and back, so new codes
// are taken while earlier reports are still leaving.
// Reset (aresetn low, synchronous) empties the queue and drops any report
// in flight. A stalled receiver holds the output word; the queue then fills
// and s_tready falls.
// ---------------------------------------------------------------------------
module char_to_keystroke_encoder_top #(
    parameter int QUEUE_DEPTH = cke_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [15:0] char_code
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cke_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [7:0] modifier_bits, [14:8] key_code, [15] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cke_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cke_pkg::*;

    desc_t       push_data;
    desc_t       head;
    queue_stat_t q_stat;
    logic        push;
    logic        pop;

    cke_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    cke_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    cke_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/cke_fifo.sv =====
// ---------------------------------------------------------------------------
// cke_fifo
// Small register queue of classified characters between front and back.
// ---------------------------------------------------------------------------
module cke_fifo #(
    parameter int DEPTH = cke_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  cke_pkg::desc_t       push_data,
    input  logic                 pop,
    output cke_pkg::desc_t       head,
    output cke_pkg::queue_stat_t stat
);
    import cke_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    desc_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cke_front.sv =====
// ---------------------------------------------------------------------------
// cke_front
// Accepts character codes, classifies them and splits alt codes into
// five decimal digits by repeated division by ten.
// ---------------------------------------------------------------------------
module cke_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cke_pkg::S_TDATA_W-1:0] s_tdata,
    input  cke_pkg::queue_stat_t          q_stat,
    output logic                          push,
    output cke_pkg::desc_t                push_data
);
    import cke_pkg::*;

    front_state_t                        state_reg, state_next;
    logic [1:0]                          cnt_reg, cnt_next;
    logic [CODE_W-1:0]                   val_reg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits_reg;

    logic                    accept;
    logic                    hi_zero;
    logic                    lo_zero;
    logic [2*CODE_W-1:0]     prod;
    logic [CODE_W-1:0]       quot;
    logic [CODE_W-1:0]       quot_x10;
    logic [CODE_W-1:0]       rem_wide;
    logic [2:0]              digit_idx;
    desc_t                   plain_desc;
    desc_t                   alt_desc;

    assign accept  = s_tvalid && s_tready;
    assign hi_zero = (s_tdata[15:8] == '0);
    assign lo_zero = (s_tdata[7:0] == '0);

    // Divide the running value by ten
    assign prod      = val_reg * DIV10_MUL;
    assign quot      = CODE_W'(prod[2*CODE_W-1:DIV10_SHIFT]);
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign rem_wide  = val_reg - quot_x10;
    assign digit_idx = 3'(NUM_DIGITS - 1) - {1'b0, cnt_reg};

    // Build the two kinds of queue words
    always_comb begin
        plain_desc           = '0;
        plain_desc.is_alt    = 1'b0;
        plain_desc.plain_mod = s_tdata[7] ? MOD_SHIFT : MOD_NONE;
        plain_desc.plain_key = s_tdata[6:0];
        alt_desc             = '0;
        alt_desc.is_alt      = 1'b1;
        alt_desc.digits      = digits_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept && !hi_zero) begin
                    state_next = FR_DIV;
                end
            end
            FR_DIV: begin
                if (cnt_reg == 2'd3) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!q_stat.full) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready  = 1'b0;
        push      = 1'b0;
        push_data = plain_desc;
        unique case (state_reg)
            FR_IDLE: begin
                s_tready = !q_stat.full;
                push     = accept && hi_zero && !lo_zero;
            end
            FR_DIV: begin
            end
            FR_PUSH: begin
                push      = !q_stat.full;
                push_data = alt_desc;
            end
            default: begin
            end
        endcase
    end

    // Digit counter
    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == FR_DIV) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Load the code, then peel digits from the low end by division by ten; the final quotient gives the top digit
    always_ff @(posedge aclk) begin
        if (state_reg == FR_IDLE && accept) begin
            val_reg <= s_tdata[CODE_W-1:0];
        end else if (state_reg == FR_DIV) begin
            val_reg               <= quot;
            digits_reg[digit_idx] <= rem_wide[DIGIT_W-1:0];
            if (cnt_reg == 2'd3) begin
                digits_reg[0] <= quot[DIGIT_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/cke_back.sv =====
// ---------------------------------------------------------------------------
// cke_back
// Walks the queued characters report by report into the output register.
// ---------------------------------------------------------------------------
module cke_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cke_pkg::desc_t                head,
    input  cke_pkg::queue_stat_t          q_stat,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cke_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cke_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    report_t           rep_reg;
    report_t           rep_now;
    logic [STEP_W-1:0] last_step;
    logic              load;

    assign rep_now   = make_report(head, step_reg);
    assign last_step = head.is_alt ? ALT_LAST_STEP : PLAIN_LAST_STEP;
    assign load      = !q_stat.empty && (!valid_reg || m_tready);
    assign pop       = load && (step_reg == last_step);

    // Advance the report counter, drop valid once taken
    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = (step_reg == last_step) ? FIRST_STEP : step_reg + 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= FIRST_STEP;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the report until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            rep_reg <= rep_now;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, rep_reg.key_code, rep_reg.modifier_bits};
    assign m_tlast  = rep_reg.last_report;

endmodule

// ===== rtl/cke_checker.sv =====
// ---------------------------------------------------------------------------
// cke_checker
// Port-level checks of the keystroke encoder, bound to the top level.
// ---------------------------------------------------------------------------
module cke_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cke_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import cke_pkg::*;

    // Output word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Reset clears the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Final report of a run is a full release
    a_last_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("final report is not a release");

    // Only none, shift or alt modifiers, pad bit clear
    a_modifier: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15] && (m_tdata[7:0] == MOD_NONE ||
            m_tdata[7:0] == MOD_SHIFT || m_tdata[7:0] == MOD_ALT))
        else $error("illegal modifier byte");

    // Every key pressed under alt is a keypad digit
    a_alt_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:0] == MOD_ALT && m_tdata[14:8] != '0 |->
            m_tdata[14:8] >= DIGIT_BASE + 7'd1 && m_tdata[14:8] <= ZERO_KEY)
        else $error("alt press outside keypad digits");

endmodule

bind char_to_keystroke_encoder_top cke_checker u_cke_checker (.*);

// ===== dv/keystroke_report_checker.sv =====
// ---------------------------------------------------------------------------
// keystroke_report_checker
// Predicts the keyboard reports for each character word taken by the
// encoder and compares every report word that leaves it, in order.
// Character words with a zero high byte are expected as a press and a
// release. Any other nonzero code is expected as an alt-code of five
// keypad digits, and a zero code is expected to type nothing.
// ---------------------------------------------------------------------------
module keystroke_report_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cke_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cke_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    output int                            error_count,
    output int                            reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import cke_pkg::*;

    localparam int SHOWN_ERRORS = 10;
    localparam int RADIX        = 10;

    report_t expected_reports[$];
    int      errors   = 0;
    int      due      = 0;
    int      word_cnt = 0;

    assign error_count = errors;
    assign reports_due = due;

    // Count a failure; print only the first few
    function automatic void flag_error(string msg);
        errors++;
        if (errors <= SHOWN_ERRORS) begin
            $display("[%0t] report word %0d: %s", $realtime, word_cnt, msg);
        end
    endfunction

    // Append the reports that type one character code
    function automatic void queue_keystrokes(logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]  rest;
        logic [DIGIT_W-1:0] digit [NUM_DIGITS];
        report_t            r;
        int                 i;
        if (code == '0) begin
            return;
        end
        // Plain scan code: press with optional shift, then release
        if (code[15:8] == '0) begin
            r.modifier_bits = code[7] ? MOD_SHIFT : MOD_NONE;
            r.key_code      = code[KEY_W-1:0];
            r.last_report   = 1'b0;
            expected_reports.push_back(r);
            r = '{MOD_NONE, KEY_NONE, 1'b1};
            expected_reports.push_back(r);
            return;
        end
        // Alt-code: split into decimal digits, most significant at index 0
        rest = code;
        for (i = NUM_DIGITS - 1; i >= 0; i--) begin
            digit[i] = DIGIT_W'(rest % RADIX);
            rest     = CODE_W'(rest / RADIX);
        end
        r = '{MOD_ALT, KEY_NONE, 1'b0};
        expected_reports.push_back(r);
        for (i = 0; i < NUM_DIGITS; i++) begin
            r.modifier_bits = MOD_ALT;
            r.key_code      = (digit[i] == '0) ? ZERO_KEY : DIGIT_BASE + KEY_W'(digit[i]);
            r.last_report   = 1'b0;
            expected_reports.push_back(r);
            r = '{MOD_ALT, KEY_NONE, 1'b0};
            expected_reports.push_back(r);
        end
        r = '{MOD_NONE, KEY_NONE, 1'b1};
        expected_reports.push_back(r);
    endfunction

    // Predict on every taken character, compare on every taken report
    always @(posedge aclk) begin
        report_t want;
        report_t got;
        if (!aresetn) begin
            expected_reports.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                queue_keystrokes(s_tdata[CODE_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                got.modifier_bits = m_tdata[MOD_W-1:0];
                got.key_code      = m_tdata[MOD_W +: KEY_W];
                got.last_report   = m_tlast;
                if (expected_reports.size() == 0) begin
                    flag_error($sformatf("unexpected report mod=%h key=%0d last=%b",
                                         got.modifier_bits, got.key_code, got.last_report));
                end else begin
                    want = expected_reports.pop_front();
                    if (got.modifier_bits !== want.modifier_bits ||
                        got.key_code !== want.key_code ||
                        got.last_report !== want.last_report) begin
                        flag_error($sformatf(
                            "expected mod=%h key=%0d last=%b, got mod=%h key=%0d last=%b",
                            want.modifier_bits, want.key_code, want.last_report,
                            got.modifier_bits, got.key_code, got.last_report));
                    end
                end
                if (m_tdata[M_TDATA_W-1] !== 1'b0) begin
                    flag_error("pad bit of m_tdata is not zero");
                end
                word_cnt++;
            end
        end
        due <= expected_reports.size();
    end

endmodule

// ===== dv/char_to_keystroke_encoder_top_tb.sv =====
// ---------------------------------------------------------------------------
// char_to_keystroke_encoder_top_tb
// Stimulus and verdict for the character to keystroke encoder.
// A directed run covers plain codes with and without shift, zero codes,
// alt-codes with leading and inner zero digits and the largest code; a
// random run follows. Both stream sides idle at random, with bursts of
// back-to-back words, and the sender drains the encoder now and then.
// The checker beside the encoder predicts and compares every report.
// ---------------------------------------------------------------------------
module char_to_keystroke_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cke_pkg::*;

    localparam int NUM_DIRECTED = 20;
    localparam int RANDOM_CHARS = 190;
    localparam int MAX_GAP      = 15;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 2000;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    bit   sender_steady   = 1'b0;
    bit   receiver_steady = 1'b0;
    int   quiet_cycles    = 0;
    int   error_count;
    int   reports_due;

    logic [CODE_W-1:0] directed_codes [NUM_DIRECTED] = '{
        16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h0081,
        16'h00FF, 16'h0055, 16'h00AA, 16'h0000, 16'h0100,
        16'h0101, 16'h2710, 16'h2711, 16'h03E8, 16'hEA60,
        16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF
    };

    char_to_keystroke_encoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    keystroke_report_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .reports_due (reports_due)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Register handshakes so the drivers see them at the falling edge
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
    end

    // Abort when no word moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Mostly alt-codes and plain codes, a few zero and boundary codes
    function automatic logic [CODE_W-1:0] pick_char_code();
        logic [CODE_W-1:0] code;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                code = {8'h00, 8'($urandom_range(1, 255))};
            end
            4: begin
                case ($urandom_range(0, 4))
                    0:       code = 16'h0000;
                    1:       code = 16'h0100;
                    2:       code = 16'hFFFF;
                    3:       code = 16'h00FF;
                    default: code = 16'h0080;
                endcase
            end
            default: begin
                code = 16'($urandom_range(16'h0100, 16'hFFFF));
            end
        endcase
        return code;
    endfunction

    // Offer one character word after a random gap and hold it until taken
    task automatic send_char(input logic [CODE_W-1:0] code);
        int gap;
        gap = draw_gap(sender_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(negedge aclk); while (!s_taken);
    endtask

    // Hold off the sender until every predicted report has left
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (reports_due != 0);
    endtask

    // Receiver: random stall before each report word, with calm stretches
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                receiver_steady = ~receiver_steady;
            end
            gap = draw_gap(receiver_steady);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_taken);
        end
    end

    // Sender: reset, directed codes, drain, random codes, verdict
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_codes[i]) begin
            send_char(directed_codes[i]);
        end
        drain_reports();
        for (int n = 0; n < RANDOM_CHARS; n++) begin
            if ($urandom_range(0, 29) == 0) begin
                sender_steady = ~sender_steady;
            end
            if ($urandom_range(0, 49) == 0) begin
                drain_reports();
            end
            send_char(pick_char_code());
        end
        drain_reports();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && reports_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cke_pkg.sv
rtl/cke_fifo.sv
rtl/cke_front.sv
rtl/cke_back.sv
rtl/char_to_keystroke_encoder_top.sv
rtl/cke_checker.sv
dv/keystroke_report_checker.sv
dv/char_to_keystroke_encoder_top_tb.sv
